// ----- src/dictionary_word_histogram_defines.svh -----
// Assertion helpers shared by the histogram RTL.
`ifndef DICTIONARY_WORD_HISTOGRAM_DEFINES_SVH
`define DICTIONARY_WORD_HISTOGRAM_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DWH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define DWH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/dwh_pkg.sv -----
package dwh_pkg;

  localparam int NAME_COUNT     = 64;
  localparam int MAX_NAME_CHARS = 8;
  localparam int COUNT_BITS     = 32;

  localparam int CMD_BITS   = 2;
  localparam int BYTE_BITS  = 8;
  localparam int IDX_BITS   = 6;
  localparam int NAME_BITS  = 64;
  localparam int LEN_BITS   = 4;
  localparam int RCOUNT_BITS = 32;
  localparam int LANE_BITS  = 3;

  // Wide enough to number every cell and to hold any entry index.
  localparam int ID_BITS = (NAME_COUNT > 64) ? $clog2(NAME_COUNT) : IDX_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TEXT  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLOSE,
    OP_LOAD,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [BYTE_BITS-1:0] data_byte;
    logic [IDX_BITS-1:0]  entry_index;
    logic [NAME_BITS-1:0] name_chars;
    logic [LEN_BITS-1:0]  name_length;
  } req_t;

  typedef struct packed {
    logic [RCOUNT_BITS-1:0] match_count;
    logic [IDX_BITS-1:0]    entry_echo;
  } rsp_t;

  // Token handed from cell to cell.
  typedef struct packed {
    op_t                   op;
    logic [IDX_BITS-1:0]   index;
    logic [NAME_BITS-1:0]  chars;
    logic [LEN_BITS-1:0]   length;
    logic [COUNT_BITS-1:0] count;
  } tok_t;

  function automatic logic [NAME_BITS-1:0] byte_mask(input logic [LEN_BITS-1:0] len);
    logic [NAME_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < NAME_BITS / 8; i++) begin
      if (LEN_BITS'(i) < len) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic is_letter(input logic [BYTE_BITS-1:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

endpackage

// ----- src/dwh_word_unit.sv -----
module dwh_word_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          req_valid,
  input  dwh_pkg::req_t req,
  output dwh_pkg::tok_t tok
);

  `include "dictionary_word_histogram_defines.svh"

  localparam logic [dwh_pkg::LEN_BITS-1:0] MaxLen = dwh_pkg::LEN_BITS'(dwh_pkg::MAX_NAME_CHARS);
  localparam logic [dwh_pkg::LEN_BITS-1:0] TooLong =
    dwh_pkg::LEN_BITS'(dwh_pkg::MAX_NAME_CHARS + 1);

  logic [dwh_pkg::NAME_BITS-1:0] word_buffer, word_buffer_next;
  logic [dwh_pkg::LEN_BITS-1:0]  word_length, word_length_next;
  logic                          letter;

  assign letter = dwh_pkg::is_letter(req.data_byte);

  always_comb begin
    word_buffer_next = word_buffer;
    word_length_next = word_length;
    tok              = '0;
    tok.op           = dwh_pkg::OP_NOP;
    tok.index        = req.entry_index;
    if (req_valid) begin
      case (dwh_pkg::cmd_t'(req.cmd))
        dwh_pkg::CMD_TEXT: begin
          if (letter) begin
            if (word_length < MaxLen) begin
              word_buffer_next[word_length[dwh_pkg::LANE_BITS-1:0]*8 +: 8] = req.data_byte;
              word_length_next = word_length + dwh_pkg::LEN_BITS'(1);
            end else begin
              word_length_next = TooLong;
            end
          end else begin
            // Close the word; empty and overlong words go down as bubbles.
            if (word_length != '0 && word_length <= MaxLen) begin
              tok.op     = dwh_pkg::OP_CLOSE;
              tok.chars  = word_buffer;
              tok.length = word_length;
            end
            word_buffer_next = '0;
            word_length_next = '0;
          end
        end
        dwh_pkg::CMD_LOAD: begin
          tok.op = dwh_pkg::OP_LOAD;
          if (req.name_length <= MaxLen) begin
            tok.chars  = req.name_chars & dwh_pkg::byte_mask(req.name_length);
            tok.length = req.name_length;
          end
        end
        dwh_pkg::CMD_READ:  tok.op = dwh_pkg::OP_READ;
        dwh_pkg::CMD_CLEAR: tok.op = dwh_pkg::OP_CLEAR;
        default:            tok.op = dwh_pkg::OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_buffer <= '0;
      word_length <= '0;
    end else if (accept) begin
      word_buffer <= word_buffer_next;
      word_length <= word_length_next;
    end
  end

  `DWH_ASSERT(a_len_bound, word_length <= TooLong, "word length beyond overlong mark")
  `DWH_ASSERT_NEXT(a_close_clears,
    accept && req.cmd == dwh_pkg::CMD_TEXT && !letter,
    word_length == '0 && word_buffer == '0, "word not cleared after separator")

endmodule

// ----- src/dwh_cell.sv -----
module dwh_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [dwh_pkg::ID_BITS-1:0]  cell_id,
  input  dwh_pkg::tok_t                tok_in,
  output dwh_pkg::tok_t                tok_out
);

  `include "dictionary_word_histogram_defines.svh"

  logic [dwh_pkg::NAME_BITS-1:0]  name_chars, name_chars_next;
  logic [dwh_pkg::LEN_BITS-1:0]   name_length, name_length_next;
  logic [dwh_pkg::COUNT_BITS-1:0] count, count_next;
  dwh_pkg::tok_t                  tok_next;
  logic                           hit;

  assign hit = dwh_pkg::ID_BITS'(tok_in.index) == cell_id;

  always_comb begin
    tok_next         = tok_in;
    name_chars_next  = name_chars;
    name_length_next = name_length;
    count_next       = count;
    case (tok_in.op)
      dwh_pkg::OP_CLOSE: begin
        if (tok_in.length == name_length && tok_in.chars == name_chars && count != '1)
          count_next = count + dwh_pkg::COUNT_BITS'(1);
      end
      dwh_pkg::OP_LOAD: begin
        if (hit) begin
          name_chars_next  = tok_in.chars;
          name_length_next = tok_in.length;
        end
      end
      dwh_pkg::OP_READ: begin
        if (hit) tok_next.count = count;
      end
      dwh_pkg::OP_CLEAR: count_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0;
      count       <= '0;
      tok_out.op  <= dwh_pkg::OP_NOP;
    end else if (advance) begin
      name_length <= name_length_next;
      count       <= count_next;
      tok_out     <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      name_chars <= name_chars_next;
    end
  end

  `DWH_ASSERT(a_count_monotonic,
    !$past(rst) && !($past(advance) && $past(tok_in.op) == dwh_pkg::OP_CLEAR)
      |-> count >= $past(count), "count dropped without a clear")

endmodule

// ----- src/dictionary_word_histogram.sv -----
// channel | valid     | stall     | payload
// --------+-----------+-----------+------------------------------------------
// request | req_valid | req_stall | req: cmd, data_byte, entry_index, names
// result  | rsp_valid | rsp_stall | rsp: match_count, entry_echo
//
// One request per cycle enters while req_stall is low; each becomes a token
// that walks the chain of NAME_COUNT cells, one cell per cycle while the
// chain advances; a count read passes the NAME_COUNT cell registers, then
// the result register. Reset clears every cell's count and length at once.
// A result held under rsp_stall freezes the whole chain and raises req_stall.
module dictionary_word_histogram (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dwh_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dwh_pkg::rsp_t rsp
);

  `include "dictionary_word_histogram_defines.svh"

  localparam logic [63:0] RspMax = 64'h0000_0000_FFFF_FFFF;

  // chain[0] is the token formed from the incoming request; chain[k+1] is the
  // register of cell k.
  dwh_pkg::tok_t chain [dwh_pkg::NAME_COUNT+1];
  logic          advance;
  logic          accept;
  logic [63:0]   wide_count;

  // Move the chain whenever the output register is empty or being taken.
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;
  assign accept    = req_valid && advance;

  dwh_word_unit u_word (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_valid (req_valid),
    .req       (req),
    .tok       (chain[0])
  );

  // One cell per name entry; commands reach every cell in arrival order,
  // so each cell sees the same history as a serial pass would.
  for (genvar k = 0; k < dwh_pkg::NAME_COUNT; k++) begin : g_cell
    dwh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .cell_id (dwh_pkg::ID_BITS'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // Clamp wide counters to the result width.
  assign wide_count = 64'(chain[dwh_pkg::NAME_COUNT].count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= chain[dwh_pkg::NAME_COUNT].op == dwh_pkg::OP_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.match_count <= (wide_count > RspMax) ? '1 : wide_count[31:0];
      rsp.entry_echo  <= chain[dwh_pkg::NAME_COUNT].index;
    end
  end

  `DWH_ASSERT_NEXT(a_read_gives_rsp,
    advance && chain[dwh_pkg::NAME_COUNT].op == dwh_pkg::OP_READ, rsp_valid,
    "read token reached chain end without a result")
  `DWH_ASSERT(a_rsp_only_from_read,
    $rose(rsp_valid) |-> $past(chain[dwh_pkg::NAME_COUNT].op) == dwh_pkg::OP_READ,
    "result raised without a read token")

endmodule
